FILE: src/srp_pkg.sv
// Shared types, codes and constants for the servo record and playback block.
package srp_pkg;

    localparam int OP_W     = 2;
    localparam int SAMPLE_W = 12;
    localparam int PULSE_W  = 11;
    localparam int MODE_W   = 2;

    localparam int STORE_DEPTH_DEF = 256;

    // Operation codes carried by an input word.
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_BUTTON = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    // Mode state codes.
    localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RECORD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PLAY   = 2'd2;

    // Dead zone limits on the sample scale.
    localparam logic [SAMPLE_W-1:0] DEAD_LO  = 12'd1948;
    localparam logic [SAMPLE_W-1:0] HI_START = 12'd2147;

    // Pulse widths in microseconds.
    localparam logic [PULSE_W-1:0] BASE_LO   = 11'd1000;
    localparam logic [PULSE_W-1:0] BASE_MID  = 11'd1500;
    localparam logic [PULSE_W-1:0] PULSE_MIN = 11'd1000;
    localparam logic [PULSE_W-1:0] PULSE_MAX = 11'd2000;

    // Scaled numerator is sample offset times 500, below 2^20.
    localparam int X_W = 20;
    localparam logic [X_W-1:0] SCALE = 20'd500;

    // Division by 1947 or 1948 is done as a multiply by a rounded-up reciprocal.
    // With a shift of 31 the error term stays below one for any 20-bit numerator.
    localparam int RECIP_SHIFT = 31;
    localparam int RECIP_W     = 21;
    localparam int PROD_W      = X_W + RECIP_W;
    localparam int Q_W         = 9;
    localparam longint unsigned DIV_LO = 64'd1947;
    localparam longint unsigned DIV_HI = 64'd1948;
    localparam logic [RECIP_W-1:0] RECIP_LO =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + DIV_LO - 64'd1) / DIV_LO);
    localparam logic [RECIP_W-1:0] RECIP_HI =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + DIV_HI - 64'd1) / DIV_HI);

    // Per-word control carried from the front stage down the pipeline.
    typedef struct packed {
        logic              upd;
        logic              from_store;
        logic              blank;
        logic [MODE_W-1:0] mode;
    } srp_item_t;

endpackage

FILE: src/srp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module srp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/srp_front.sv
// Front stage: mode sequencer, record and play pointers, and store access.
module srp_front #(
    parameter int STORE_DEPTH = srp_pkg::STORE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [srp_pkg::OP_W-1:0]          operation,
    input  logic [srp_pkg::SAMPLE_W-1:0]      sample,
    output logic                              ram_we,
    output logic [$clog2(STORE_DEPTH)-1:0]    ram_waddr,
    output logic [srp_pkg::SAMPLE_W-1:0]      ram_wdata,
    output logic                              ram_re,
    output logic [$clog2(STORE_DEPTH)-1:0]    ram_raddr,
    output srp_pkg::srp_item_t                item
);

    import srp_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(STORE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(STORE_DEPTH - 1);

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [AW-1:0]     play_reg, play_next;
    logic [CW-1:0]     count_reg, count_next;
    // Recording always fills from entry 0, so the entries ever written form a
    // prefix of the store; fill_reg is its length and anything beyond reads zero.
    logic [CW-1:0]     fill_reg, fill_next;
    logic [CW-1:0]     count_inc;

    assign count_inc = count_reg + CW'(1);

    always_comb
    begin
        mode_next       = mode_reg;
        play_next       = play_reg;
        count_next      = count_reg;
        fill_next       = fill_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[AW-1:0];
        ram_wdata       = sample;
        ram_re          = 1'b0;
        ram_raddr       = play_reg;
        item.upd        = 1'b0;
        item.from_store = 1'b0;
        item.blank      = 1'b0;
        if (accept)
        begin
            unique case (operation)
                OP_SAMPLE:
                begin
                    if (mode_reg == MODE_MANUAL || mode_reg == MODE_RECORD)
                    begin
                        item.upd = 1'b1;
                        if (mode_reg == MODE_RECORD && count_reg < DEPTH_C)
                        begin
                            ram_we     = 1'b1;
                            count_next = count_inc;
                            if (count_inc > fill_reg)
                            begin
                                fill_next = count_inc;
                            end
                        end
                    end
                end
                OP_BUTTON:
                begin
                    priority if (mode_reg == MODE_MANUAL)
                    begin
                        mode_next  = MODE_RECORD;
                        play_next  = '0;
                        count_next = '0;
                    end
                    else if (mode_reg == MODE_RECORD)
                    begin
                        mode_next = MODE_PLAY;
                        play_next = '0;
                    end
                    else
                    begin
                        // A press during playback is ignored.
                    end
                end
                OP_TICK:
                begin
                    if (mode_reg == MODE_PLAY)
                    begin
                        ram_re          = 1'b1;
                        item.upd        = 1'b1;
                        item.from_store = 1'b1;
                        item.blank      = (CW'(play_reg) >= fill_reg);
                        play_next       = (play_reg == LAST_IDX) ? '0 : play_reg + AW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
        item.mode = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_MANUAL;
            play_reg  <= '0;
            count_reg <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            play_reg  <= play_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

FILE: src/srp_map.sv
// Two-step sample to pulse width mapper: scaling stage, then reciprocal multiply.
module srp_map (
    input  logic                         clk,
    input  logic                         en,
    input  logic [srp_pkg::SAMPLE_W-1:0] value,
    output logic [srp_pkg::PULSE_W-1:0]  pulse
);

    import srp_pkg::*;

    logic [X_W-1:0]      x_next, x_reg;
    logic [PULSE_W-1:0]  base_next, base_reg;
    logic                hi_next, hi_reg;
    logic [PROD_W-1:0]   prod;
    logic [Q_W-1:0]      quot;

    always_comb
    begin
        priority if (value < DEAD_LO)
        begin
            x_next    = X_W'(value) * SCALE;
            base_next = BASE_LO;
            hi_next   = 1'b0;
        end
        else if (value < HI_START)
        begin
            x_next    = '0;
            base_next = BASE_MID;
            hi_next   = 1'b0;
        end
        else
        begin
            x_next    = X_W'(value - HI_START) * SCALE;
            base_next = BASE_MID;
            hi_next   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            base_reg <= base_next;
            hi_reg   <= hi_next;
        end
    end

    assign prod  = PROD_W'(x_reg) * PROD_W'(hi_reg ? RECIP_HI : RECIP_LO);
    assign quot  = Q_W'(prod >> RECIP_SHIFT);
    assign pulse = base_reg + PULSE_W'(quot);

endmodule

FILE: src/servo_record_playback.sv
// Servo pulse controller with manual, record and playback modes.
// An accepted word passes through stage 1, stage 2 and the output register in turn.
// Throughput: one word per cycle while out_stall is low; stages advance
// independently, so bubbles close up.
// Reset clears mode, pointers and fill count at once and sets the pulse to 1500 us;
// the store needs no clearing pass since entries past the fill count read as zero.
module servo_record_playback #(
    parameter int STORE_DEPTH = srp_pkg::STORE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [srp_pkg::OP_W-1:0]     operation,
    input  logic [srp_pkg::SAMPLE_W-1:0] sample,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [srp_pkg::PULSE_W-1:0]  pulse_us,
    output logic [srp_pkg::MODE_W-1:0]   mode,
    output logic                         record_led
);

    import srp_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);

    // Handshake and stage movement. Each stage takes a new word whenever it is
    // empty or the word it holds moves on in the same cycle.
    logic accept;
    logic out_free;
    logic s2_free;
    logic s1_free;

    // Store port signals.
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    // Stage 1 holds the word while the store read completes.
    srp_item_t           front_item;
    logic                s1_valid_reg;
    srp_item_t           s1_item_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [SAMPLE_W-1:0] s1_value;

    // Stage 2 holds the word while the mapper multiplies.
    logic                s2_valid_reg;
    logic                s2_upd_reg;
    logic [MODE_W-1:0]   s2_mode_reg;
    logic [PULSE_W-1:0]  map_pulse;

    // Output register; pulse_reg is also the controller's current pulse width.
    logic                out_valid_reg;
    logic [PULSE_W-1:0]  pulse_reg;
    logic [MODE_W-1:0]   mode_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_stall = !s1_free;
    assign accept   = in_valid && s1_free;

    // Mode sequencing and all store writes and reads happen at acceptance, in
    // word order, so a playback read always follows the last record write.
    srp_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (operation),
        .sample    (sample),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .item      (front_item)
    );

    srp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_item_reg   <= front_item;
            s1_sample_reg <= sample;
        end
    end

    // The read data stays put while stage 1 stalls, since no new read is issued
    // until the stage frees up. Entries past the fill count count as zero.
    always_comb
    begin
        if (s1_item_reg.from_store)
        begin
            s1_value = s1_item_reg.blank ? '0 : ram_rdata;
        end
        else
        begin
            s1_value = s1_sample_reg;
        end
    end

    srp_map u_map (
        .clk   (clk),
        .en    (s2_free),
        .value (s1_value),
        .pulse (map_pulse)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free)
        begin
            s2_upd_reg  <= s1_item_reg.upd;
            s2_mode_reg <= s1_item_reg.mode;
        end
    end

    // Words leave in order, so the pulse held here is the width in force when
    // the next word arrives; words that do not move the servo repeat it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pulse_reg     <= BASE_MID;
            mode_reg      <= MODE_MANUAL;
        end
        else if (out_free)
        begin
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                mode_reg <= s2_mode_reg;
                if (s2_upd_reg)
                begin
                    pulse_reg <= map_pulse;
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign pulse_us   = pulse_reg;
    assign mode       = mode_reg;
    assign record_led = (mode_reg == MODE_RECORD);

endmodule

FILE: src/srp_checker.sv
// Port-level checker for the servo record and playback block, bound to the top level.
module srp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [srp_pkg::PULSE_W-1:0]  pulse_us,
    input logic [srp_pkg::MODE_W-1:0]   mode,
    input logic                         record_led
);

    import srp_pkg::*;

    // Set once a playback word has been delivered; playback is never left.
    logic seen_play_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_play_reg <= 1'b0;
        end
        else if (out_valid && !out_stall && mode == MODE_PLAY)
        begin
            seen_play_reg <= 1'b1;
        end
    end

    a_led_tracks_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (record_led == (mode == MODE_RECORD)))
        else $error("record_led disagrees with mode");

    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pulse_us >= PULSE_MIN && pulse_us <= PULSE_MAX))
        else $error("pulse width outside servo range");

    a_play_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && seen_play_reg) |-> (mode == MODE_PLAY))
        else $error("mode left playback");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(pulse_us) && $stable(mode)))
        else $error("stalled result word changed");

    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && $past(!out_valid)) |-> !in_stall)
        else $error("input stalled with the output side idle");

endmodule

bind servo_record_playback srp_checker u_srp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pulse_us   (pulse_us),
    .mode       (mode),
    .record_led (record_led)
);
